### hdl/urlas_pkg.sv
// Package for the URL authority splitter: character codes, limits and the
// structs passed between the top level and the search lanes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package urlas_pkg;

    localparam int MAX_URL_LENGTH = 256;
    localparam int POS_W          = 9;    // holds 0 .. MAX_URL_LENGTH
    localparam int PORT_W         = 16;
    localparam int ACC_W          = 20;   // port*10 + 9 before saturation

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [PORT_W-1:0] PORT_MAX     = 16'hFFFF;
    localparam logic [PORT_W-1:0] DEFAULT_PORT = 16'd80;
    localparam logic [POS_W-1:0]  MAX_POS      = POS_W'(MAX_URL_LENGTH);

    // progress states while hunting for "://"
    typedef enum logic [2:0] {
        MARK_NONE  = 3'b001,
        MARK_COLON = 3'b010,
        MARK_SLASH = 3'b100
    } mark_state_t;

    typedef struct packed {
        logic step;    // a character is consumed by this lane
        logic clear;   // end of URL: back to reset
    } lane_ctl_t;

    typedef struct packed {
        logic              colon_seen;
        logic [POS_W-1:0]  colon_index;
        logic              slash_seen;
        logic [POS_W-1:0]  slash_index;
        logic [PORT_W-1:0] port_value;
    } lane_view_t;

endpackage

`default_nettype wire

### hdl/urlas_track.sv
// One search lane: first colon, first slash and the port digits after the colon.
// Depends on urlas_pkg. view shows the state including the current character.
`timescale 1ns / 1ps
`default_nettype none

module urlas_track (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire urlas_pkg::lane_ctl_t      ctl,
    input  wire logic [7:0]                char_code,
    input  wire logic [urlas_pkg::POS_W-1:0] pos,
    output urlas_pkg::lane_view_t          view
);

    logic                          colon_seen_reg, colon_seen_next;
    logic [urlas_pkg::POS_W-1:0]   colon_index_reg, colon_index_next;
    logic                          digits_active_reg, digits_active_next;
    logic [urlas_pkg::PORT_W-1:0]  port_value_reg, port_value_next;
    logic                          slash_seen_reg, slash_seen_next;
    logic [urlas_pkg::POS_W-1:0]   slash_index_reg, slash_index_next;

    logic                          is_digit;
    logic [3:0]                    digit;
    logic [urlas_pkg::ACC_W-1:0]   acc;
    logic [urlas_pkg::ACC_W-1:0]   pv_ext;

    always_comb begin
        is_digit = (char_code >= urlas_pkg::CH_ZERO) && (char_code <= urlas_pkg::CH_NINE);
        digit    = 4'(char_code - urlas_pkg::CH_ZERO);
        pv_ext   = urlas_pkg::ACC_W'(port_value_reg);
        acc      = (pv_ext << 3) + (pv_ext << 1) + urlas_pkg::ACC_W'(digit);

        colon_seen_next    = colon_seen_reg;
        colon_index_next   = colon_index_reg;
        digits_active_next = digits_active_reg;
        port_value_next    = port_value_reg;
        slash_seen_next    = slash_seen_reg;
        slash_index_next   = slash_index_reg;

        if (digits_active_reg) begin
            if (is_digit) begin
                port_value_next = (acc > urlas_pkg::ACC_W'(urlas_pkg::PORT_MAX))
                                  ? urlas_pkg::PORT_MAX : acc[urlas_pkg::PORT_W-1:0];
            end else begin
                digits_active_next = 1'b0;
            end
        end
        if (char_code == urlas_pkg::CH_COLON && !colon_seen_reg) begin
            colon_seen_next    = 1'b1;
            colon_index_next   = pos;
            digits_active_next = 1'b1;
            port_value_next    = '0;
        end
        if (char_code == urlas_pkg::CH_SLASH && !slash_seen_reg) begin
            slash_seen_next  = 1'b1;
            slash_index_next = pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            colon_seen_reg    <= 1'b0;
            colon_index_reg   <= '0;
            digits_active_reg <= 1'b0;
            port_value_reg    <= '0;
            slash_seen_reg    <= 1'b0;
            slash_index_reg   <= '0;
        end else if (ctl.step) begin
            colon_seen_reg    <= colon_seen_next;
            colon_index_reg   <= colon_index_next;
            digits_active_reg <= digits_active_next;
            port_value_reg    <= port_value_next;
            slash_seen_reg    <= slash_seen_next;
            slash_index_reg   <= slash_index_next;
        end
    end

    always_comb begin
        if (ctl.step) begin
            view.colon_seen  = colon_seen_next;
            view.colon_index = colon_index_next;
            view.slash_seen  = slash_seen_next;
            view.slash_index = slash_index_next;
            view.port_value  = port_value_next;
        end else begin
            view.colon_seen  = colon_seen_reg;
            view.colon_index = colon_index_reg;
            view.slash_seen  = slash_seen_reg;
            view.slash_index = slash_index_reg;
            view.port_value  = port_value_reg;
        end
    end

endmodule

`default_nettype wire

### hdl/url_authority_splitter_core.sv
// URL authority splitter top level: input register, scheme-mark tracking,
// two search lanes (urlas_track) and the result register. Uses urlas_pkg.
// The result is registered on m_* once the last character leaves the input
// register, which holds it while an unaccepted result is still on m_*;
// otherwise one character is taken per cycle. Reset (aresetn, synchronous)
// clears all parse state and sets default_port to 80.
`timescale 1ns / 1ps
`default_nettype none

module url_authority_splitter_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,

    input  wire logic        s_valid,
    output      logic        s_ready,
    input  wire logic [7:0]  s_char_code,
    input  wire logic        s_last_char,

    output      logic        m_valid,
    input  wire logic        m_ready,
    output      logic        m_scheme_found,
    output      logic        m_port_present,
    output      logic        m_path_present,
    output      logic [2:0]  m_found_code,
    output      logic [8:0]  m_host_start,
    output      logic [8:0]  m_host_end,
    output      logic [7:0]  m_path_start,
    output      logic [8:0]  m_url_length,
    output      logic [15:0] m_port_number,
    output      logic        m_overflow
);

    logic [15:0]   default_port_reg;

    logic          in_valid_reg;
    logic [7:0]    in_char_reg;
    logic          in_last_reg;

    logic [urlas_pkg::POS_W-1:0] pos_reg, pos_next;
    urlas_pkg::mark_state_t      mark_progress_reg, mark_progress_next;
    logic                        mark_seen_reg, mark_seen_next;
    logic [urlas_pkg::POS_W-1:0] mark_end_reg, mark_end_next;
    logic                        overflow_reg, overflow_next;

    logic          out_free, advance, in_range, finish;

    urlas_pkg::lane_ctl_t  ctl0, ctl1;
    urlas_pkg::lane_view_t view0, view1, sel;

    logic                        r_scheme, r_port, r_path;
    logic [urlas_pkg::POS_W-1:0] r_host_end;

    assign out_free = !m_valid || m_ready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || advance;
    assign in_range = pos_reg < urlas_pkg::MAX_POS;
    assign finish   = advance && in_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_port_reg <= urlas_pkg::DEFAULT_PORT;
        end else if (cfg_wr_en) begin
            default_port_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_code;
            in_last_reg <= s_last_char;
        end
    end

    // scheme mark "://" and position bookkeeping
    always_comb begin
        pos_next           = pos_reg;
        mark_progress_next = mark_progress_reg;
        mark_seen_next     = mark_seen_reg;
        mark_end_next      = mark_end_reg;
        overflow_next      = overflow_reg;
        if (!in_range) begin
            overflow_next = 1'b1;
        end else begin
            pos_next = pos_reg + 1'b1;
            if (!mark_seen_reg) begin
                if (mark_progress_reg == urlas_pkg::MARK_SLASH &&
                    in_char_reg == urlas_pkg::CH_SLASH) begin
                    mark_seen_next     = 1'b1;
                    mark_end_next      = pos_reg + 1'b1;
                    mark_progress_next = urlas_pkg::MARK_NONE;
                end else if (in_char_reg == urlas_pkg::CH_COLON) begin
                    mark_progress_next = urlas_pkg::MARK_COLON;
                end else if (mark_progress_reg == urlas_pkg::MARK_COLON &&
                             in_char_reg == urlas_pkg::CH_SLASH) begin
                    mark_progress_next = urlas_pkg::MARK_SLASH;
                end else begin
                    mark_progress_next = urlas_pkg::MARK_NONE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || finish) begin
            pos_reg           <= '0;
            mark_progress_reg <= urlas_pkg::MARK_NONE;
            mark_seen_reg     <= 1'b0;
            mark_end_reg      <= '0;
            overflow_reg      <= 1'b0;
        end else if (advance) begin
            pos_reg           <= pos_next;
            mark_progress_reg <= mark_progress_next;
            mark_seen_reg     <= mark_seen_next;
            mark_end_reg      <= mark_end_next;
            overflow_reg      <= overflow_next;
        end
    end

    // lane 0 searches the whole URL, lane 1 only past the scheme mark
    assign ctl0.step  = advance && in_range;
    assign ctl0.clear = finish;
    assign ctl1.step  = advance && in_range && mark_seen_reg;
    assign ctl1.clear = finish;

    urlas_track u_lane_whole (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl0),
        .char_code (in_char_reg),
        .pos       (pos_reg),
        .view      (view0)
    );

    urlas_track u_lane_after (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl1),
        .char_code (in_char_reg),
        .pos       (pos_reg),
        .view      (view1)
    );

    always_comb begin
        sel        = mark_seen_next ? view1 : view0;
        r_scheme   = mark_seen_next;
        r_port     = sel.colon_seen;
        r_path     = sel.slash_seen;
        r_host_end = r_port ? sel.colon_index : (r_path ? sel.slash_index : pos_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (finish) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_scheme_found <= r_scheme;
            m_port_present <= r_port;
            m_path_present <= r_path;
            m_found_code   <= {r_scheme, r_port, r_path};
            m_host_start   <= r_scheme ? mark_end_next : '0;
            m_host_end     <= r_host_end;
            m_path_start   <= r_path ? sel.slash_index[7:0] : 8'd0;
            m_url_length   <= pos_next;
            m_port_number  <= r_port ? sel.port_value : default_port_reg;
            m_overflow     <= overflow_next;
        end
    end

    a_code_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_found_code == {m_scheme_found, m_port_present, m_path_present})
        else $error("found_code disagrees with the found flags");

    a_host_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_host_start <= m_host_end) && (m_host_end <= m_url_length))
        else $error("host bounds out of order");

    a_overflow_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_overflow) |-> m_url_length == urlas_pkg::MAX_POS)
        else $error("overflow without full length");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= urlas_pkg::MAX_POS)
        else $error("character position past the maximum");

    a_clear_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> (pos_reg == '0) && !mark_seen_reg && !overflow_reg)
        else $error("parse state not cleared after the last character");

endmodule

`default_nettype wire
